>>> src/vvs_pkg.sv
package vvs_pkg;

   localparam int IN_PORTS_DEF     = 8;
   localparam int VCS_PER_PORT_DEF = 16;
   localparam int MASK_VCS         = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   localparam logic [1:0] POLICY_MODE_RST  = 2'd0;
   localparam logic [4:0] VCS_PER_VNET_RST = 5'd4;
   localparam logic [3:0] NEXT_LOCAL_RST   = 4'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POLICY_MODE      = 2'd0,
      CSR_VCS_PER_VNET     = 2'd1,
      CSR_NEXT_LOCAL_PORTS = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      POLICY_VOQ       = 2'd0,
      POLICY_NEXT_PORT = 2'd1,
      POLICY_DEST_TILE = 2'd2
   } policy_type;

   typedef struct packed {
      logic [2:0]  in_port;
      logic [3:0]  in_vc;
      logic [3:0]  vnet;
      logic [2:0]  route_port;
      logic        has_next_hop;
      logic [2:0]  next_hop_port;
      logic [7:0]  dest_tile;
      logic [15:0] idle_mask;
   } req_type;

   typedef struct packed {
      logic       request_valid;
      logic [2:0] request_port;
      logic [3:0] request_vc;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SETUP,
      ST_SCAN,
      ST_DIVIDE,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clr_we;
      logic load;
      logic mem_rd;
      logic ptr_we;
      logic scan_init;
      logic scan_step;
      logic div_start;
      logic check;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic in_range;
      logic final_hop;
      logic use_div;
      logic scan_stop;
      logic div_busy;
   } stat_type;

endpackage

>>> src/voq_vc_selector_unit.sv
// channel   dir  ports                              payload
// req       in   req_valid req_ready req_data       req_type, one head packet
// rsp       out  rsp_valid rsp_ready rsp_data       rsp_type, one request
// csr       in   csr_valid csr_ready csr_index/data register write, always ready
//
// one item at a time; final-hop items decode, set up, then scan 1..n offsets one per cycle
// (n: vcs_per_vnet clamped to 1..16); modulo policies wait on the 2-bit-per-cycle modulo
// unit, then check; voq and unused policies check after decode; out-of-range items go to
// done; after reset a sweep, req blocked, zeroes all IN_PORTS * VCS_PER_PORT pointers;
// a stalled rsp holds the result register; the next beat waits until it drains
module voq_vc_selector_unit
   import vvs_pkg::*;
#(
   parameter int IN_PORTS     = IN_PORTS_DEF,
   parameter int VCS_PER_PORT = VCS_PER_PORT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   vvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   vvs_datapath #(
      .IN_PORTS     (IN_PORTS),
      .VCS_PER_PORT (VCS_PER_PORT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

>>> src/vvs_mod.sv
module vvs_mod
   import vvs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [7:0] dividend,
   input  logic [4:0] divisor,
   output logic [3:0] remainder,
   output logic       busy
);

   logic [7:0] dvd_ff, dvd_in;
   logic [4:0] rem_ff, rem_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       busy_ff, busy_in;

   // two restoring steps per cycle
   always_comb begin
      logic [7:0] d;
      logic [4:0] r;
      d = dvd_ff;
      r = rem_ff;
      for (int i = 0; i < 2; i++) begin
         r = {r[3:0], d[7]};
         d = {d[6:0], 1'b0};
         if (r >= divisor) begin
            r = r - divisor;
         end
      end
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = 5'd0;
         cnt_in  = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = d;
         rem_in = r;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign remainder = rem_ff[3:0];
   assign busy      = busy_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("modulo restarted while busy");

endmodule

>>> src/vvs_datapath.sv
module vvs_datapath
   import vvs_pkg::*;
#(
   parameter int IN_PORTS     = IN_PORTS_DEF,
   parameter int VCS_PER_PORT = VCS_PER_PORT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  req_type                req_data,
   output rsp_type                rsp_data,
   input  cmd_type                cmd,
   output stat_type               stat
);

   localparam int DEPTH  = IN_PORTS * VCS_PER_PORT;
   localparam int SLOT_W = $clog2(DEPTH);

   logic [1:0] mode_ff;
   logic [4:0] vcs_ff;
   logic [3:0] nlp_ff;
   logic [4:0] n;

   req_type           item_ff;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              in_range_ff, in_range_in;
   logic [7:0]        base_ff, base_in;

   logic [3:0]        ptr_mem [DEPTH];
   logic [3:0]        rd_ff;
   logic [3:0]        ptr_next;
   logic [SLOT_W-1:0] clr_cnt_ff;

   logic [3:0] off_ff, cnt_ff;
   logic [4:0] nxt5;
   logic [3:0] scan_off;
   logic [3:0] voq_off, map_off, cand_off, mod_rem;
   logic       mapped;
   logic [7:0] cand_vc;
   logic       cand_idle;
   logic       found_ff;
   logic [3:0] pick_ff;
   rsp_type    rsp_ff;
   logic       mod_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= POLICY_MODE_RST;
         vcs_ff  <= VCS_PER_VNET_RST;
         nlp_ff  <= NEXT_LOCAL_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_POLICY_MODE:      mode_ff <= csr_data[1:0];
            CSR_VCS_PER_VNET:     vcs_ff  <= csr_data[4:0];
            CSR_NEXT_LOCAL_PORTS: nlp_ff  <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (vcs_ff == 5'd0) begin
         n = 5'd1;
      end else if (vcs_ff > 5'd16) begin
         n = 5'd16;
      end else begin
         n = vcs_ff;
      end
   end

   assign slot_in = SLOT_W'(32'(req_data.in_port) * VCS_PER_PORT + 32'(req_data.in_vc));
   assign in_range_in = (32'(req_data.in_port) < IN_PORTS) &&
                        (32'(req_data.in_vc) < VCS_PER_PORT);
   assign base_in = {4'd0, req_data.vnet} * {3'd0, n};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff     <= req_data;
         slot_ff     <= slot_in;
         in_range_ff <= in_range_in;
         base_ff     <= base_in;
      end
   end

   // pointer store, cleared by a sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_we) begin
         clr_cnt_ff <= clr_cnt_ff + SLOT_W'(1);
      end
   end

   assign ptr_next = (({1'b0, rd_ff} + 5'd1) >= n) ? 4'd0 : rd_ff + 4'd1;

   always_ff @(posedge clock) begin
      if (cmd.clr_we) begin
         ptr_mem[clr_cnt_ff] <= 4'd0;
      end else if (cmd.ptr_we) begin
         ptr_mem[slot_ff] <= ptr_next;
      end
      if (cmd.mem_rd) begin
         rd_ff <= ptr_mem[slot_ff];
      end
   end

   vvs_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  ((mode_ff == POLICY_DEST_TILE) ? item_ff.dest_tile
                                                : {5'd0, item_ff.next_hop_port}),
      .divisor   (n),
      .remainder (mod_rem),
      .busy      (mod_busy)
   );

   assign nxt5     = {1'b0, off_ff} + 5'd1;
   assign scan_off = (nxt5 >= n) ? 4'd0 : nxt5[3:0];

   assign voq_off = ({1'b0, item_ff.next_hop_port} >= nlp_ff)
                  ? {1'b0, item_ff.next_hop_port} - nlp_ff + 4'd1 : 4'd0;
   assign map_off = (mode_ff == POLICY_VOQ) ? voq_off : mod_rem;
   assign mapped  = ((mode_ff == POLICY_VOQ) && ({1'b0, voq_off} < n)) ||
                    (mode_ff == POLICY_NEXT_PORT) || (mode_ff == POLICY_DEST_TILE);

   assign cand_off  = cmd.check ? map_off : scan_off;
   assign cand_vc   = base_ff + {4'd0, cand_off};
   assign cand_idle = (cand_vc < 8'(MASK_VCS)) && (32'(cand_vc) < VCS_PER_PORT) &&
                      item_ff.idle_mask[cand_vc[3:0]];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         found_ff <= 1'b0;
         pick_ff  <= 4'd0;
      end else if (cmd.scan_step && cand_idle) begin
         found_ff <= 1'b1;
         pick_ff  <= cand_vc[3:0];
      end else if (cmd.check && mapped && cand_idle) begin
         found_ff <= 1'b1;
         pick_ff  <= cand_vc[3:0];
      end
      if (cmd.scan_init) begin
         off_ff <= rd_ff;
         cnt_ff <= 4'd0;
      end else if (cmd.scan_step) begin
         off_ff <= scan_off;
         cnt_ff <= cnt_ff + 4'd1;
      end
      if (cmd.out_load) begin
         rsp_ff.request_valid <= found_ff;
         rsp_ff.request_port  <= found_ff ? item_ff.route_port : 3'd0;
         rsp_ff.request_vc    <= found_ff ? pick_ff : 4'd0;
      end
   end

   assign rsp_data = rsp_ff;

   assign stat.clr_last  = (clr_cnt_ff == SLOT_W'(DEPTH - 1));
   assign stat.in_range  = in_range_ff;
   assign stat.final_hop = !item_ff.has_next_hop;
   assign stat.use_div   = (mode_ff == POLICY_NEXT_PORT) || (mode_ff == POLICY_DEST_TILE);
   assign stat.scan_stop = cand_idle || (cnt_ff == 4'(n - 5'd1));
   assign stat.div_busy  = mod_busy;

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clr_we && cmd.ptr_we))
      else $error("pointer store written by sweep and update at once");

endmodule

>>> src/vvs_ctrl.sv
module vvs_ctrl
   import vvs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (stat.clr_last) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_DECODE;
         ST_DECODE: begin
            if (!stat.in_range) begin
               state_in = ST_DONE;
            end else if (stat.final_hop) begin
               state_in = ST_SETUP;
            end else if (stat.use_div) begin
               state_in = ST_DIVIDE;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_SETUP:  state_in = ST_SCAN;
         ST_SCAN:   if (stat.scan_stop) state_in = ST_DONE;
         ST_DIVIDE: if (!stat.div_busy) state_in = ST_CHECK;
         ST_CHECK:  state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR:  cmd.clr_we = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DECODE: begin
            cmd.mem_rd    = stat.in_range && stat.final_hop;
            cmd.div_start = stat.in_range && !stat.final_hop && stat.use_div;
         end
         ST_SETUP: begin
            cmd.ptr_we    = 1'b1;
            cmd.scan_init = 1'b1;
         end
         ST_SCAN:   cmd.scan_step = 1'b1;
         ST_DIVIDE: ;
         ST_CHECK:  cmd.check = 1'b1;
         ST_DONE:   cmd.out_load = out_free;
         default: ;
      endcase
   end

   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second beat accepted while an item is in flight");

   a_no_result_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result pending during pointer sweep");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result register load lost");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import vvs_pkg::*;

   localparam int IDLE_LIMIT   = 4000;
   localparam int SETTLE_WAIT  = 12;
   localparam int NUM_PHASES   = 11;
   localparam int PHASE_ITEMS  = 120;

   class voq_scoreboard;
      logic [3:0] rr_ptr [IN_PORTS_DEF*VCS_PER_PORT_DEF];
      logic [1:0] mode;
      logic [4:0] vcs;
      logic [3:0] local_ports;
      rsp_type    expected_rsp_q [$];
      int         mismatches;

      function new();
         foreach (rr_ptr[i]) rr_ptr[i] = '0;
         mode        = POLICY_MODE_RST;
         vcs         = VCS_PER_VNET_RST;
         local_ports = NEXT_LOCAL_RST;
         mismatches  = 0;
      endfunction

      function int unsigned vc_count();
         if (vcs == 0) return 1;
         if (vcs > 16) return 16;
         return 32'(vcs);
      endfunction

      function int pending();
         return expected_rsp_q.size();
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (csr_index_type'(idx))
            CSR_POLICY_MODE:      mode        = data[1:0];
            CSR_VCS_PER_VNET:     vcs         = data[4:0];
            CSR_NEXT_LOCAL_PORTS: local_ports = data[3:0];
            default: ;
         endcase
      endfunction

      function bit vc_idle(int unsigned vc, logic [15:0] mask);
         if (vc >= MASK_VCS || vc >= VCS_PER_PORT_DEF) return 1'b0;
         return mask[vc];
      endfunction

      function rsp_type select_vc(req_type r);
         int unsigned n, base, off, nxt, slot, pick;
         bit found, mapped;
         rsp_type res;
         n      = vc_count();
         base   = r.vnet * n;
         found  = 1'b0;
         pick   = 0;
         mapped = 1'b1;
         off    = 0;
         if (r.in_port < IN_PORTS_DEF && r.in_vc < VCS_PER_PORT_DEF) begin
            slot = r.in_port * VCS_PER_PORT_DEF + r.in_vc;
            if (!r.has_next_hop) begin
               off = 32'(rr_ptr[slot]);
               nxt = off + 1;
               rr_ptr[slot] = (nxt >= n) ? 4'd0 : nxt[3:0];
               for (int i = 0; i < n && !found; i++) begin
                  off++;
                  if (off >= n) off = 0;
                  if (vc_idle(base + off, r.idle_mask)) begin
                     found = 1'b1;
                     pick  = base + off;
                  end
               end
            end else begin
               case (mode)
                  POLICY_VOQ: begin
                     if (r.next_hop_port >= local_ports)
                        off = r.next_hop_port - local_ports + 1;
                     if (off >= n) mapped = 1'b0;
                  end
                  POLICY_NEXT_PORT: off = r.next_hop_port % n;
                  POLICY_DEST_TILE: off = r.dest_tile % n;
                  default: mapped = 1'b0;
               endcase
               if (mapped && vc_idle(base + off, r.idle_mask)) begin
                  found = 1'b1;
                  pick  = base + off;
               end
            end
         end
         res.request_valid = found;
         res.request_port  = found ? r.route_port : 3'd0;
         res.request_vc    = found ? pick[3:0] : 4'd0;
         return res;
      endfunction

      function void note_request(req_type r);
         expected_rsp_q.push_back(select_vc(r));
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp_rsp;
         if (expected_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: valid %0b port %0d vc %0d",
                        got.request_valid, got.request_port, got.request_vc);
            return;
         end
         exp_rsp = expected_rsp_q.pop_front();
         if (got.request_valid !== exp_rsp.request_valid ||
             got.request_port !== exp_rsp.request_port ||
             got.request_vc !== exp_rsp.request_vc) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected valid %0b port %0d vc %0d, got valid %0b port %0d vc %0d",
                        exp_rsp.request_valid, exp_rsp.request_port, exp_rsp.request_vc,
                        got.request_valid, got.request_port, got.request_vc);
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   voq_scoreboard sb = new();
   int idle_cycles = 0;
   int stall_left  = 0;
   int stall_kind  = 0;

   int unsigned phase_mode  [NUM_PHASES] = '{1, 2, 0, 1, 3, 0, 2, 0, 1, 2, 0};
   int unsigned phase_vcs   [NUM_PHASES] = '{1, 16, 16, 3, 5, 0, 31, 8, 17, 7, 2};
   int unsigned phase_local [NUM_PHASES] = '{0, 8, 0, 8, 15, 9, 3, 31, 2, 1, 4};

   voq_vc_selector_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // beat monitors
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_kind <= $urandom_range(0, 2);
         stall_left <= $urandom_range(20, 120);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_kind)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type make_req(int unsigned port, int unsigned ivc, int unsigned vnet,
                                        int unsigned rport, bit hop, int unsigned nport,
                                        int unsigned tile, int unsigned mask);
      req_type r;
      r.in_port       = port[2:0];
      r.in_vc         = ivc[3:0];
      r.vnet          = vnet[3:0];
      r.route_port    = rport[2:0];
      r.has_next_hop  = hop;
      r.next_hop_port = nport[2:0];
      r.dest_tile     = tile[7:0];
      r.idle_mask     = mask[15:0];
      return r;
   endfunction

   function automatic req_type make_rand_req();
      req_type r;
      int unsigned vnet_span, bit_sel;
      r = make_req($urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                   $urandom, $urandom, $urandom);
      // concentrate on a few input vcs so the pointers keep moving
      if ($urandom_range(0, 9) < 6) begin
         r.in_port = 3'($urandom_range(0, 1));
         r.in_vc   = 4'($urandom_range(0, 2));
      end
      vnet_span = 16 / sb.vc_count();
      case ($urandom_range(0, 9))
         0, 1:    ;
         2:       r.vnet = 4'(vnet_span - 1);
         default: r.vnet = 4'($urandom_range(0, vnet_span - 1));
      endcase
      bit_sel = $urandom_range(0, 15);
      case ($urandom_range(0, 5))
         0: r.idle_mask = 16'hffff;
         1: r.idle_mask = 16'h0000;
         2: r.idle_mask = 16'h0001 << bit_sel;
         3: r.idle_mask = ~(16'h0001 << bit_sel);
         4: r.idle_mask = 16'($urandom & $urandom & $urandom);
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_req(input req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic drain_results(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic run_random(input int count);
      int burst_left, gap, pause_at;
      burst_left = 0;
      pause_at   = $urandom_range(10, count - 10);
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) begin
            drain_results(0);
         end else if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 30);
         end
         send_req(make_rand_req());
         if (burst_left > 0) burst_left--;
      end
   endtask

   initial begin
      req_type directed_q [$];
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: voq, four vcs per vnet, one local port
      directed_q.push_back(make_req(0, 0, 0, 7, 0, 0, 0, 16'hffff));
      directed_q.push_back(make_req(0, 0, 0, 7, 0, 0, 0, 16'hffff));
      directed_q.push_back(make_req(0, 0, 0, 7, 0, 0, 0, 16'hffff));
      directed_q.push_back(make_req(0, 0, 0, 7, 0, 0, 0, 16'hffff));
      directed_q.push_back(make_req(0, 0, 0, 3, 0, 0, 0, 16'h0000));
      directed_q.push_back(make_req(0, 0, 0, 3, 0, 0, 0, 16'h0001));
      directed_q.push_back(make_req(0, 0, 1, 5, 0, 7, 255, 16'h0010));
      directed_q.push_back(make_req(7, 15, 15, 7, 0, 7, 255, 16'hffff));
      directed_q.push_back(make_req(7, 15, 3, 7, 0, 7, 255, 16'h8000));
      directed_q.push_back(make_req(1, 2, 0, 1, 1, 0, 0, 16'hffff));
      directed_q.push_back(make_req(1, 2, 0, 1, 1, 1, 0, 16'hffff));
      directed_q.push_back(make_req(1, 2, 0, 1, 1, 3, 0, 16'hffff));
      directed_q.push_back(make_req(1, 2, 0, 1, 1, 4, 0, 16'hffff));
      directed_q.push_back(make_req(1, 2, 0, 1, 1, 7, 255, 16'hffff));
      directed_q.push_back(make_req(1, 2, 3, 7, 1, 3, 255, 16'h8000));
      directed_q.push_back(make_req(1, 2, 3, 7, 1, 3, 255, 16'h7fff));
      directed_q.push_back(make_req(2, 9, 15, 7, 1, 0, 255, 16'hffff));
      directed_q.push_back(make_req(3, 5, 2, 0, 1, 2, 128, 16'h0000));
      foreach (directed_q[i]) send_req(directed_q[i]);
      drain_results(SETTLE_WAIT);

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_reg(CSR_POLICY_MODE, phase_mode[p]);
         write_reg(CSR_VCS_PER_VNET, phase_vcs[p]);
         write_reg(CSR_NEXT_LOCAL_PORTS, phase_local[p]);
         csr_valid <= 1'b0;
         @(posedge clock);
         run_random(PHASE_ITEMS);
         drain_results(SETTLE_WAIT);
      end

      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

>>> sim.f
src/vvs_pkg.sv
src/vvs_mod.sv
src/vvs_datapath.sv
src/vvs_ctrl.sv
src/voq_vc_selector_unit.sv
tb/sv/testbench.sv
